// ===== sv/glu_pkg.sv =====
// Shared widths, types and divider handshake structs for the GCD and LCM unit.
package glu_pkg;

  localparam int WIDTH = 16;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [2*WIDTH-1:0] dword_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_resp_t;

endpackage

// ===== sv/glu_div.sv =====
// Shared restoring divider that produces one quotient bit per cycle.
module glu_div (
  input  logic              clk,
  input  logic              rst,
  input  glu_pkg::div_req_t  req,
  output glu_pkg::div_resp_t resp
);
  import glu_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  word_t            rem;
  word_t            quo;
  word_t            dsr;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   trial;

  assign shifted = {rem, quo[WIDTH-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      cnt <= CNT_W'(WIDTH - 1);
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (trial[WIDTH]) begin
        rem <= shifted[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b0};
      end else begin
        rem <= trial[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b1};
      end
    end
  end

  assign resp.done      = done;
  assign resp.quotient  = quo;
  assign resp.remainder = rem;

  a_no_start_when_busy : assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("Divider started while busy.");

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("Divider done without a run.");

endmodule

// ===== sv/gcd_lcm_unit.sv =====
// Top level: Euclid sequencer around a shared divider, with multiply and result register.
// Euclid takes at most 23 remainder steps for 16-bit operands.
// Each remainder step and the final quotient take one pass of the bit-serial divider.
// Both operands zero go from idle straight to S_DONE, skipping the divider and the multiply.
// One item at a time; the next item is taken once the result sits in the output register.
// Reset (synchronous, active high) returns the sequencer to idle and clears result_valid.
module gcd_lcm_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  glu_pkg::word_t first_operand,
  input  glu_pkg::word_t second_operand,
  output logic           result_valid,
  input  logic           result_stall,
  output glu_pkg::word_t divisor,
  output glu_pkg::word_t multiple,
  output logic           multiple_overflow
);
  import glu_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EUC_CHK  = 3'd1;
  localparam logic [2:0] S_EUC_RUN  = 3'd2;
  localparam logic [2:0] S_QUOT     = 3'd3;
  localparam logic [2:0] S_QUOT_RUN = 3'd4;
  localparam logic [2:0] S_MUL      = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  word_t      x;
  word_t      y;
  word_t      a_r;
  word_t      b_r;
  dword_t     prod;
  logic       zero_r;
  logic       accept;
  logic       out_free;
  div_req_t   div_req;
  div_resp_t  div_resp;

  glu_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    div_req.start    = (state == S_EUC_CHK && y != '0) || state == S_QUOT;
    div_req.dividend = (state == S_QUOT) ? a_r : x;
    div_req.divisor  = (state == S_QUOT) ? x : y;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (first_operand == '0 && second_operand == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_EUC_CHK;
          end
        end
      end
      S_EUC_CHK:  state_next = (y == '0) ? S_QUOT : S_EUC_RUN;
      S_EUC_RUN:  if (div_resp.done) state_next = S_EUC_CHK;
      S_QUOT:     state_next = S_QUOT_RUN;
      S_QUOT_RUN: if (div_resp.done) state_next = S_MUL;
      S_MUL:      state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x      <= first_operand;
      y      <= second_operand;
      a_r    <= first_operand;
      b_r    <= second_operand;
      zero_r <= (first_operand == '0 && second_operand == '0);
    end else if (state == S_EUC_RUN && div_resp.done) begin
      x <= y;
      y <= div_resp.remainder;
    end
    if (state == S_MUL) begin
      prod <= dword_t'(div_resp.quotient) * dword_t'(b_r);
    end
    if (state == S_DONE && out_free) begin
      if (zero_r) begin
        divisor           <= '0;
        multiple          <= '0;
        multiple_overflow <= 1'b1;
      end else begin
        divisor           <= x;
        multiple          <= prod[WIDTH-1:0];
        multiple_overflow <= |prod[2*WIDTH-1:WIDTH];
      end
    end
  end

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE) else $error("Item accepted but sequencer idle.");

  a_done_only_when_waiting : assert property (@(posedge clk) disable iff (rst)
    div_resp.done |-> state == S_EUC_RUN || state == S_QUOT_RUN)
    else $error("Divider result arrived outside a wait state.");

  a_gcd_nonzero : assert property (@(posedge clk) disable iff (rst)
    state == S_QUOT |-> x != '0) else $error("Divisor zero before quotient step.");

  a_result_loaded : assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free |=> result_valid && state == S_IDLE)
    else $error("Finished item not presented.");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the GCD and LCM unit with directed and random operand items.
`timescale 1ns / 100ps

module testbench;
  import glu_pkg::*;

  localparam int DIRECTED_ROWS = 19;
  localparam int RANDOM_ITEMS = 750;
  localparam int QUIET_ITEMS = 120;
  localparam int HOLD_AT = 200;
  localparam int DRAIN_AT = 400;
  localparam int LONG_HOLD_CYCLES = 1200;
  localparam int SETTLE_CYCLES = 500;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    word_t gcd;
    word_t lcm_low;
    logic  too_wide;
  } gl_result_t;

  typedef struct packed {
    word_t      a;
    word_t      b;
    logic       typed;
    gl_result_t res;
  } stim_row_t;

  logic  clk;
  logic  rst;
  logic  item_valid;
  logic  item_stall;
  word_t first_operand;
  word_t second_operand;
  logic  result_valid;
  logic  result_stall;
  word_t divisor;
  word_t multiple;
  logic  multiple_overflow;

  gl_result_t pending_results[$];
  stim_row_t  stim_table[DIRECTED_ROWS];
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         quiet;
  bit         long_hold_req = 1'b0;

  gcd_lcm_unit uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .first_operand(first_operand),
    .second_operand(second_operand),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .divisor(divisor),
    .multiple(multiple),
    .multiple_overflow(multiple_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic gl_result_t gcd_lcm_predict(input word_t a, input word_t b);
    word_t      x;
    word_t      y;
    word_t      r;
    word_t      q;
    dword_t     prod;
    gl_result_t res;
    res = '0;
    if (a == '0 && b == '0) begin
      res.too_wide = 1'b1;
      return res;
    end
    x = a;
    y = b;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    q = a / x;
    prod = dword_t'(q) * dword_t'(b);
    res.gcd = x;
    res.lcm_low = prod[WIDTH-1:0];
    res.too_wide = |prod[2*WIDTH-1:WIDTH];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    mismatches++;
    $display("mismatch in %s: got %h, expected %h, cycle %0d", what, got, want, cycle_count);
  endtask

  task automatic offer_item(input word_t a, input word_t b, input logic typed,
                            input gl_result_t typed_res);
    gl_result_t want;
    want = typed ? typed_res : gcd_lcm_predict(a, b);
    @(negedge clk);
    item_valid <= 1'b1;
    first_operand <= a;
    second_operand <= b;
    do @(posedge clk); while (item_stall);
    pending_results.push_back(want);
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk);
    item_valid <= 1'b0;
    first_operand <= word_t'($urandom);
    second_operand <= word_t'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    idle_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    gl_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result divisor", divisor, '0);
      end else begin
        want = pending_results.pop_front();
        if (divisor !== want.gcd) report_mismatch("divisor", divisor, want.gcd);
        if (multiple !== want.lcm_low) report_mismatch("multiple", multiple, want.lcm_low);
        if (multiple_overflow !== want.too_wide) begin
          report_mismatch("multiple_overflow", word_t'(multiple_overflow),
                          word_t'(want.too_wide));
        end
      end
    end
  end

  initial begin : receiver
    int hold;
    bit hold_done;
    hold_done = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        result_stall <= 1'b1;
        hold = 0;
        while (hold < LONG_HOLD_CYCLES) begin
          @(negedge clk);
          hold++;
        end
        result_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin : sender
    int    i;
    int    g;
    int    steps;
    int    fx;
    int    fy;
    int    ft;
    word_t a;
    word_t b;
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    first_operand = '0;
    second_operand = '0;
    quiet = 1'b0;

    stim_table = '{
      '{16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, 1'b1}},
      '{16'h0000, 16'h0005, 1'b1, '{16'h0005, 16'h0000, 1'b0}},
      '{16'h0007, 16'h0000, 1'b1, '{16'h0007, 16'h0000, 1'b0}},
      '{16'h0000, 16'hFFFF, 1'b1, '{16'hFFFF, 16'h0000, 1'b0}},
      '{16'hFFFF, 16'h0000, 1'b1, '{16'hFFFF, 16'h0000, 1'b0}},
      '{16'h0000, 16'h8000, 1'b1, '{16'h8000, 16'h0000, 1'b0}},
      '{16'h0001, 16'h0001, 1'b1, '{16'h0001, 16'h0001, 1'b0}},
      '{16'hFFFF, 16'hFFFF, 1'b1, '{16'hFFFF, 16'hFFFF, 1'b0}},
      '{16'h0001, 16'hFFFF, 1'b1, '{16'h0001, 16'hFFFF, 1'b0}},
      '{16'hFFFF, 16'h0001, 1'b1, '{16'h0001, 16'hFFFF, 1'b0}},
      '{16'h8000, 16'h8000, 1'b1, '{16'h8000, 16'h8000, 1'b0}},
      '{16'hAAAA, 16'h5555, 1'b1, '{16'h5555, 16'hAAAA, 1'b0}},
      '{16'd12,   16'd18,   1'b1, '{16'd6,    16'd36,   1'b0}},
      '{16'hFFFF, 16'hFFFE, 1'b0, '0},
      '{16'd46368, 16'd28657, 1'b0, '0},
      '{16'd256,  16'd255,  1'b0, '0},
      '{16'd256,  16'd257,  1'b0, '0},
      '{16'h0003, 16'h8000, 1'b0, '0},
      '{16'hFFFE, 16'hFFFD, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      offer_item(stim_table[i].a, stim_table[i].b, stim_table[i].typed, stim_table[i].res);
    end
    drain_results();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) long_hold_req = 1'b1;
      if (i == DRAIN_AT) drain_results();
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if (!quiet && (i < HOLD_AT || i >= HOLD_AT + 10) && $urandom_range(0, 3) == 0) begin
        idle_sender($urandom_range(1, 17));
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          a = word_t'($urandom);
          b = word_t'($urandom);
        end
        8, 9, 10, 11, 12: begin
          g = $urandom_range(1, 255);
          a = word_t'(g * $urandom_range(0, 65535 / g));
          b = word_t'(g * $urandom_range(0, 65535 / g));
        end
        13, 14: begin
          a = word_t'($urandom_range(0, 15));
          b = word_t'($urandom_range(0, 15));
        end
        15, 16: begin
          steps = $urandom_range(1, 22);
          fx = 1;
          fy = 1;
          repeat (steps) begin
            ft = fx + fy;
            fx = fy;
            fy = ft;
          end
          g = $urandom_range(1, 65535 / fy);
          a = word_t'(fx * g);
          b = word_t'(fy * g);
          if ($urandom_range(0, 1) == 1) begin
            a = word_t'(fy * g);
            b = word_t'(fx * g);
          end
        end
        17, 18: begin
          b = word_t'($urandom);
          case ($urandom_range(0, 5))
            0: a = '0;
            1: begin a = b; b = '0; end
            2: begin a = '0; b = '0; end
            3: a = b;
            4: a = 16'h0001;
            default: a = 16'hFFFF;
          endcase
        end
        default: begin
          a = word_t'(1 << $urandom_range(0, 15));
          b = $urandom_range(0, 1) == 1 ? word_t'(1 << $urandom_range(0, 15))
                                        : word_t'(16'hFFFF - $urandom_range(0, 15));
        end
      endcase
      offer_item(a, b, 1'b0, '0);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/glu_pkg.sv
sv/glu_div.sv
sv/gcd_lcm_unit.sv
verif/testbench.sv
